/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the bus adapter register block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is off while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* hdl/basr_pkg.sv */
// ----------------------------------------------------------------------------
// Bus adapter register package
// Types, register indexes and bit masks shared by the register block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package basr_pkg;

  typedef enum logic [1:0] {
    REQ_READ    = 2'd0,
    REQ_WRITE   = 2'd1,
    REQ_ACCESS  = 2'd2,
    REQ_CONFIRM = 2'd3
  } req_type_e;

  localparam logic [4:0] IDX_CFG     = 5'd0;
  localparam logic [4:0] IDX_CTL     = 5'd1;
  localparam logic [4:0] IDX_ERR     = 5'd13;
  localparam logic [4:0] IDX_TMO     = 5'd14;
  localparam logic [4:0] IDX_FAULT   = 5'd15;
  localparam logic [4:0] IDX_SILO    = 5'd16;
  localparam logic [4:0] IDX_MAINT   = 5'd17;

  localparam logic [31:0] CFG_WORD   = 32'h0040_0010;
  localparam logic [2:0]  CTL_RESET  = 3'b011;
  localparam logic [1:0]  CTL_OUT_EN = 2'd1;

  localparam logic [31:0] FS_RMASK   = 32'h031F_0000;
  localparam logic [31:0] FS_WMASK   = 32'h0314_0000;
  localparam logic [31:0] FS_W1C     = 32'h0008_0000;
  localparam logic [31:0] SC_RMASK   = 32'hFFFF_0000;
  localparam logic [31:0] SC_WMASK   = 32'h7FFF_0000;
  localparam logic [31:0] SC_LOCK    = 32'h8000_0000;
  localparam logic [31:0] MT_RMASK   = 32'hFFFF_FF00;
  localparam logic [31:0] MT_WMASK   = 32'hFFFF_F900;

  localparam logic [15:0] ER_RMASK   = 16'hFDFE;
  localparam logic [15:0] ER_CRDIE   = 16'h8000;
  localparam logic [15:0] ER_CRD     = 16'h4000;
  localparam logic [15:0] ER_TMO     = 16'h1000;
  localparam logic [15:0] ER_STA     = 16'h0C00;
  localparam logic [15:0] ER_CNF     = 16'h0100;
  localparam logic [15:0] ER_IBTMO   = 16'h0040;
  localparam logic [15:0] ER_IBCNF   = 16'h0008;
  localparam logic [15:0] ER_MULT    = 16'h0004;
  localparam logic [15:0] ER_W1C     = 16'h70C0;
  localparam logic [15:0] ER_TMO_GRP = ER_TMO | ER_STA | ER_CNF | ER_MULT;
  localparam logic [15:0] ER_IBT_GRP = ER_IBTMO | ER_STA | ER_IBCNF;

  typedef struct packed {
    req_type_e   req_type;
    logic [29:0] phys_addr;
    logic [31:0] write_data;
    logic        node_ok;
    logic        virt_ref;
    logic [1:0]  cur_mode;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        access_ok;
    logic        crd_interrupt;
    logic        machine_check;
  } rsp_t;

endpackage

/* hdl/basr_regs.sv */
// ----------------------------------------------------------------------------
// Bus adapter register file
// Holds the adapter registers and works out the result of one request word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module basr_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_en_i,
  input  basr_pkg::req_t req_i,
  input  logic           cfg_we_i,
  input  logic [31:0]    cfg_wdata_i,
  output basr_pkg::rsp_t rsp_o
);

  logic [31:0] fault_mask_q, fault_mask_d;
  logic [2:0]  ctl_q, ctl_d;
  logic [31:0] fault_q, fault_d;
  logic [31:0] silo_q, silo_d;
  logic [31:0] maint_q, maint_d;
  logic [15:0] err_q, err_d;
  logic [31:0] tmo_q, tmo_d;
  logic        crd_q, crd_d;

  logic [4:0]  idx;
  logic [15:0] wd_lo;
  logic [31:0] tmo_capture;

  assign idx         = req_i.phys_addr[6:2];
  assign wd_lo       = req_i.write_data[15:0];
  assign tmo_capture = {req_i.virt_ref ? req_i.cur_mode : 2'b00, req_i.virt_ref, 1'b0,
                        req_i.phys_addr[29:2]};

  always_comb begin
    fault_mask_d = cfg_we_i ? cfg_wdata_i : fault_mask_q;
    ctl_d        = ctl_q;
    fault_d      = fault_q;
    silo_d       = silo_q;
    maint_d      = maint_q;
    err_d        = err_q;
    tmo_d        = tmo_q;
    crd_d        = crd_q;
    rsp_o        = '0;

    case (req_i.req_type)
      basr_pkg::REQ_READ: begin
        case (idx)
          basr_pkg::IDX_CFG:   rsp_o.read_data = basr_pkg::CFG_WORD;
          basr_pkg::IDX_CTL:   rsp_o.read_data = {ctl_q, 29'd0};
          basr_pkg::IDX_ERR:   rsp_o.read_data = {16'd0, err_q & basr_pkg::ER_RMASK};
          basr_pkg::IDX_TMO:   rsp_o.read_data = tmo_q;
          basr_pkg::IDX_FAULT: rsp_o.read_data = fault_q & (basr_pkg::FS_RMASK | fault_mask_q);
          basr_pkg::IDX_SILO:  rsp_o.read_data = silo_q & basr_pkg::SC_RMASK;
          basr_pkg::IDX_MAINT: rsp_o.read_data = maint_q & basr_pkg::MT_RMASK;
          default:             rsp_o.read_data = '0;
        endcase
      end
      basr_pkg::REQ_WRITE: begin
        case (idx)
          basr_pkg::IDX_CTL: ctl_d = req_i.write_data[31:29];
          basr_pkg::IDX_ERR: begin
            err_d = (err_q & ~basr_pkg::ER_CRDIE) | (wd_lo & basr_pkg::ER_CRDIE);
            err_d = err_d & ~(wd_lo & basr_pkg::ER_W1C);
            if ((wd_lo & basr_pkg::ER_TMO) != '0) begin
              err_d = err_d & ~basr_pkg::ER_TMO_GRP;
            end
            if ((wd_lo & basr_pkg::ER_IBTMO) != '0) begin
              err_d = err_d & ~basr_pkg::ER_IBT_GRP;
            end
            crd_d = ((err_d & basr_pkg::ER_CRDIE) != '0) && ((err_d & basr_pkg::ER_CRD) != '0);
          end
          basr_pkg::IDX_FAULT: begin
            fault_d = (fault_q & ~basr_pkg::FS_WMASK) | (req_i.write_data & basr_pkg::FS_WMASK);
            fault_d = fault_d & ~(req_i.write_data & basr_pkg::FS_W1C);
          end
          basr_pkg::IDX_SILO: begin
            silo_d = (silo_q & ~(basr_pkg::SC_LOCK | basr_pkg::SC_WMASK))
                   | (req_i.write_data & basr_pkg::SC_WMASK);
          end
          basr_pkg::IDX_MAINT: begin
            maint_d = (maint_q & ~basr_pkg::MT_WMASK) | (req_i.write_data & basr_pkg::MT_WMASK);
          end
          default: ;
        endcase
      end
      basr_pkg::REQ_ACCESS: begin
        if (ctl_q[basr_pkg::CTL_OUT_EN] && req_i.node_ok) begin
          rsp_o.access_ok = 1'b1;
        end else if ((err_q & basr_pkg::ER_TMO) == '0) begin
          tmo_d = tmo_capture;
          err_d = err_q | basr_pkg::ER_TMO;
        end else begin
          err_d = err_q | basr_pkg::ER_MULT;
        end
      end
      default: begin
        if ((err_q & basr_pkg::ER_CNF) != '0) begin
          err_d = err_q | basr_pkg::ER_MULT;
        end else begin
          err_d = err_q | basr_pkg::ER_CNF;
        end
        rsp_o.machine_check = 1'b1;
      end
    endcase

    rsp_o.crd_interrupt = crd_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_mask_q <= '0;
      ctl_q        <= basr_pkg::CTL_RESET;
      fault_q      <= '0;
      silo_q       <= '0;
      maint_q      <= '0;
      err_q        <= '0;
      tmo_q        <= '0;
      crd_q        <= 1'b0;
    end else begin
      fault_mask_q <= fault_mask_d;
      if (req_en_i) begin
        ctl_q   <= ctl_d;
        fault_q <= fault_d;
        silo_q  <= silo_d;
        maint_q <= maint_d;
        err_q   <= err_d;
        tmo_q   <= tmo_d;
        crd_q   <= crd_d;
      end
    end
  end

endmodule

/* hdl/bus_adapter_status_registers.sv */
// Bus adapter status register block. Each accepted request word (register
// read, register write, outbound bus access or error confirm) produces exactly
// one result word, presented from an output register in the cycle after
// acceptance. A new request can be accepted every cycle; requests are held off
// only while that output register is full and the downstream side stalls.
// The user must load the fault read mask via cfg_we_i and cfg_wdata_i while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
// Bus adapter status registers
// Top level: request handshake, register file and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bus_adapter_status_registers (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [29:0] phys_addr_i,
  input  logic [31:0] write_data_i,
  input  logic        node_ok_i,
  input  logic        virt_ref_i,
  input  logic [1:0]  cur_mode_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] read_data_o,
  output logic        access_ok_o,
  output logic        crd_interrupt_o,
  output logic        machine_check_o
);

  basr_pkg::req_t req;
  basr_pkg::rsp_t rsp;
  basr_pkg::rsp_t rsp_q;
  logic           out_valid_q, out_valid_d;
  logic           accept;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_d = accept || (out_valid_q && out_stall_i);

  assign req.req_type   = basr_pkg::req_type_e'(req_type_i);
  assign req.phys_addr  = phys_addr_i;
  assign req.write_data = write_data_i;
  assign req.node_ok    = node_ok_i;
  assign req.virt_ref   = virt_ref_i;
  assign req.cur_mode   = cur_mode_i;

  basr_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_en_i    (accept),
    .req_i       (req),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rsp_o       (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = rsp_q.read_data;
  assign access_ok_o     = rsp_q.access_ok;
  assign crd_interrupt_o = rsp_q.crd_interrupt;
  assign machine_check_o = rsp_q.machine_check;

endmodule

/* hdl/basr_checker.sv */
// ----------------------------------------------------------------------------
// Bus adapter register checker
// Port-level assertions on the register block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module basr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] read_data_o,
  input logic        access_ok_o,
  input logic        machine_check_o
);

  `ASSERT_CLK(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(read_data_o), "stalled result word changed")
  `ASSERT_CLK(a_accept_result, in_valid_i && !in_stall_o |=> out_valid_o, "accepted word produced no result")
  `ASSERT_CLK_ALWAYS(a_stall_cause, in_stall_o |-> out_valid_o && out_stall_i, "input stalled without a full stalled output")
  `ASSERT_CLK(a_result_kind, out_valid_o && (access_ok_o || machine_check_o) |-> read_data_o == 32'd0 && !(access_ok_o && machine_check_o), "result word mixes request kinds")

endmodule

bind bus_adapter_status_registers basr_checker u_basr_checker (.*);
